>>> design/assert_macros.svh
// Assertion macros shared by the delta list timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define DLTQ_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DLTQ_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/dltq_pkg.sv
// Shared types and constants of the delta list timer queue.
`default_nettype none
package dltq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = 5;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_ARM1   = 3'd1;
    localparam logic [2:0] ACT_ARMC   = 3'd2;
    localparam logic [2:0] ACT_CANCEL = 3'd3;
    localparam logic [2:0] ACT_QUERY  = 3'd4;

    localparam logic [1:0] KIND_EXPIRY  = 2'd0;
    localparam logic [1:0] KIND_REMAIN  = 2'd1;
    localparam logic [1:0] KIND_NOTARM  = 2'd2;
    localparam logic [1:0] KIND_ISARM   = 2'd3;

    localparam logic REG_MIN_DELAY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_TCHK,
        ST_CAN,
        ST_INS,
        ST_QRY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/dltq_cell.sv
// One cell of the ordered timer chain: holds a valid flag, slot id and delta.
`default_nettype none
module dltq_cell
    import dltq_pkg::*;
#(
    parameter int W = 37
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cell_ctl_t    ctl,
    input  wire logic [W-1:0] shift_in,
    input  wire logic [W-1:0] load_in,
    output logic      [W-1:0] q
);

    logic [W-1:0] ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else if (ctl.shift) begin
            ent_reg <= shift_in;
        end else if (ctl.load) begin
            ent_reg <= load_in;
        end
    end

    assign q = ent_reg;

endmodule
`default_nettype wire

>>> design/delta_list_timer_queue_top.sv
// Top level of the delta list timer queue: control sequencer and cell chain.
//
// Armed timers sit in a chain of NUM_TIMERS cells in expiry order, each cell
// holding its delta to the cell before it; the head cell holds ticks to the
// next expiry. Arm, cancel and query are each accepted and then make one pass
// that rotates the whole chain once; a query then gives its result beat. A
// tick decrements the head and checks it, and ends there if nothing expired.
// Otherwise, for every expired timer, it checks the head, makes one pass to
// unlink it, one more pass to re-arm it when continuous, and gives its result
// beat. Errors go straight to their result beat; ignored items end once
// accepted. A result beat waits while the one before it is still held by the
// receiver.
// No reset sweep is needed: the chain clears at reset.
`default_nettype none
module delta_list_timer_queue_top
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], timer_id[6:3], delay[38:7], zero pad
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // kind[1:0], timer_id_res[5:2], remaining[37:6], zero pad
    output logic      [39:0] m_tdata,
    output logic             m_tlast
);

    `include "assert_macros.svh"

    localparam int IDW   = $clog2(NUM_TIMERS);
    localparam int TB    = TIME_BITS;
    localparam int ENT_W = 1 + IDW + TB;
    localparam int EW    = (TB > 32) ? TB : 32;
    localparam int SW    = $clog2(NUM_TIMERS);

    // config
    logic [7:0] min_delay_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_delay_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_DELAY) begin
            min_delay_reg <= pwdata[7:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DELAY) ? {24'd0, min_delay_reg} : 32'd0;

    // input fields
    logic [2:0]  in_action;
    logic [3:0]  in_tid;
    logic [31:0] in_delay;
    logic [7:0]  id8;
    logic        id_ok;
    logic [IDW-1:0] in_id;
    assign in_action = s_tdata[2:0];
    assign in_tid    = s_tdata[6:3];
    assign in_delay  = s_tdata[38:7];
    assign id8       = {4'd0, in_tid};
    assign id_ok     = id8 < 8'(NUM_TIMERS);
    assign in_id     = id8[IDW-1:0];

    logic [EW-1:0] de0, de1, de2;
    logic [TB-1:0] eff_delay;
    always_comb begin
        de0 = EW'(in_delay);
        de1 = (de0 < EW'(min_delay_reg)) ? EW'(min_delay_reg) : de0;
        de2 = (de1 < EW'(1)) ? EW'(1) : de1;
        if (de2 > EW'({TB{1'b1}})) begin
            de2 = EW'({TB{1'b1}});
        end
        eff_delay = de2[TB-1:0];
    end

    // chain
    logic [ENT_W-1:0] cell_q [NUM_TIMERS];
    cell_ctl_t        cell_ctl [NUM_TIMERS];
    logic [ENT_W-1:0] tail_in;
    logic [ENT_W-1:0] head_load;
    logic [NUM_TIMERS-1:0] valid_vec;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
            logic [ENT_W-1:0] sin;
            if (g == NUM_TIMERS - 1) begin : g_tail
                assign sin = tail_in;
            end else begin : g_mid
                assign sin = cell_q[g+1];
            end
            dltq_cell #(.W(ENT_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl[g]),
                .shift_in (sin),
                .load_in  (head_load),
                .q        (cell_q[g])
            );
            assign valid_vec[g] = cell_q[g][ENT_W-1];
        end
    endgenerate

    logic           cur_v, nxt_v;
    logic [IDW-1:0] cur_id, nxt_id;
    logic [TB-1:0]  cur_d, nxt_d;
    assign cur_v  = cell_q[0][ENT_W-1];
    assign cur_id = cell_q[0][TB+IDW-1:TB];
    assign cur_d  = cell_q[0][TB-1:0];
    assign nxt_v  = cell_q[1][ENT_W-1];
    assign nxt_id = cell_q[1][TB+IDW-1:TB];
    assign nxt_d  = cell_q[1][TB-1:0];

    // control state
    state_t          state_reg, state_next;
    logic [SW-1:0]   step_reg;
    logic            tick_mode_reg;
    logic            done_reg;
    logic            shmode_reg;
    logic [ENT_W-1:0] hold_reg;
    logic [IDW-1:0]  tok_id_reg;
    logic [TB-1:0]   tok_rem_reg;
    logic [TB-1:0]   sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]      res_kind_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [TB-1:0]   reload_reg [NUM_TIMERS];

    logic last_step;
    logic accept;
    logic out_free;
    logic can_match;
    logic ins_here;
    logic head_zero;
    logic tick_more;
    logic emit_last;
    assign last_step = step_reg == SW'(NUM_TIMERS - 1);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign can_match = cur_v && cur_id == tok_id_reg;
    assign ins_here  = !hold_reg[ENT_W-1] && !done_reg && (!cur_v || cur_d >= tok_rem_reg);
    assign head_zero = cur_v && cur_d == '0;
    assign tick_more = cnt_reg < CNT_W'(MAX_RESULTS) && head_zero;
    assign emit_last = !tick_mode_reg || cnt_reg + CNT_W'(1) >= CNT_W'(MAX_RESULTS)
                       || !head_zero;

    // pass output into the tail cell
    always_comb begin
        tail_in = cell_q[0];
        case (state_reg)
            ST_INS: begin
                if (hold_reg[ENT_W-1]) begin
                    tail_in = hold_reg;
                end else if (ins_here) begin
                    tail_in = {1'b1, tok_id_reg, tok_rem_reg};
                end
            end
            ST_CAN: begin
                if (shmode_reg || can_match) begin
                    if (last_step) begin
                        tail_in = '0;
                    end else if (!shmode_reg && nxt_v) begin
                        tail_in = {1'b1, nxt_id, nxt_d + cur_d};
                    end else begin
                        tail_in = cell_q[1];
                    end
                end
            end
            default: tail_in = cell_q[0];
        endcase
    end
    assign head_load = {cur_v, cur_id, cur_d - TB'(1)};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_TICK) begin
                        state_next = ST_DEC;
                    end else if (id_ok && (in_action == ACT_ARM1 || in_action == ACT_ARMC)) begin
                        state_next = armed_reg[in_id] ? ST_EMIT : ST_INS;
                    end else if (id_ok && (in_action == ACT_CANCEL || in_action == ACT_QUERY)) begin
                        if (!armed_reg[in_id]) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = (in_action == ACT_CANCEL) ? ST_CAN : ST_QRY;
                        end
                    end
                end
            end
            ST_DEC:  state_next = ST_TCHK;
            ST_TCHK: state_next = tick_more ? ST_CAN : ST_IDLE;
            ST_CAN: begin
                if (last_step) begin
                    if (!tick_mode_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = (reload_reg[tok_id_reg] != '0) ? ST_INS : ST_EMIT;
                    end
                end
            end
            ST_INS:  if (last_step) state_next = tick_mode_reg ? ST_EMIT : ST_IDLE;
            ST_QRY:  if (last_step) state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (tick_mode_reg && !emit_last) ? ST_TCHK : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic chain_shift;
    logic head_dec;
    always_comb begin
        s_tready    = 1'b0;
        chain_shift = 1'b0;
        head_dec    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DEC:  head_dec = cur_v && cur_d != '0;
            ST_CAN, ST_INS, ST_QRY: chain_shift = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            cell_ctl[i].shift = chain_shift;
            cell_ctl[i].load  = (i == 0) ? head_dec : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= '0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            shmode_reg    <= 1'b0;
            hold_reg      <= '0;
            tick_mode_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (chain_shift) begin
                step_reg <= last_step ? '0 : step_reg + SW'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    done_reg   <= 1'b0;
                    shmode_reg <= 1'b0;
                    hold_reg   <= '0;
                    step_reg   <= '0;
                    cnt_reg    <= '0;
                    sum_reg    <= '0;
                    tok_id_reg <= in_id;
                    tok_rem_reg <= eff_delay;
                    if (accept) begin
                        tick_mode_reg <= in_action == ACT_TICK;
                        if (in_action == ACT_ARM1 || in_action == ACT_ARMC) begin
                            res_kind_reg <= KIND_ISARM;
                            if (id_ok && !armed_reg[in_id]) begin
                                armed_reg[in_id]  <= 1'b1;
                                reload_reg[in_id] <= (in_action == ACT_ARMC) ? eff_delay : '0;
                            end
                        end else begin
                            res_kind_reg <= (in_action == ACT_QUERY && armed_reg[in_id])
                                            ? KIND_REMAIN : KIND_NOTARM;
                            if (id_ok && in_action == ACT_CANCEL) begin
                                armed_reg[in_id] <= 1'b0;
                            end
                        end
                    end
                end
                ST_TCHK: begin
                    tok_id_reg   <= cur_id;
                    res_kind_reg <= KIND_EXPIRY;
                    shmode_reg   <= 1'b0;
                    done_reg     <= 1'b0;
                    hold_reg     <= '0;
                    if (tick_more) begin
                        armed_reg[cur_id] <= 1'b0;
                    end
                end
                ST_CAN: begin
                    if (can_match) begin
                        shmode_reg <= 1'b1;
                    end
                    if (last_step && tick_mode_reg && reload_reg[tok_id_reg] != '0) begin
                        tok_rem_reg <= reload_reg[tok_id_reg];
                        armed_reg[tok_id_reg] <= 1'b1;
                    end
                end
                ST_INS: begin
                    if (hold_reg[ENT_W-1]) begin
                        hold_reg <= cell_q[0];
                    end else if (ins_here) begin
                        done_reg <= 1'b1;
                        hold_reg <= {cur_v, cur_id, cur_d - tok_rem_reg};
                    end else if (!done_reg) begin
                        tok_rem_reg <= tok_rem_reg - cur_d;
                    end
                end
                ST_QRY: begin
                    if (!done_reg && cur_v) begin
                        sum_reg <= sum_reg + cur_d;
                        if (cur_id == tok_id_reg) begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default: done_reg <= done_reg;
            endcase
        end
    end

    // result register
    logic [EW-1:0]  sum_ext;
    logic [7:0]     oid8;
    logic           m_tvalid_reg;
    logic [39:0]    m_tdata_reg;
    logic           m_tlast_reg;
    assign sum_ext = EW'(sum_reg);
    assign oid8    = 8'(tok_id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= {2'b00,
                            (res_kind_reg == KIND_REMAIN) ? sum_ext[31:0] : 32'd0,
                            oid8[3:0], res_kind_reg};
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `DLTQ_ASSERT_IMPLY(a_arm_count, aclk, aresetn, state_reg == ST_IDLE,
        $countones(armed_reg) == $countones(valid_vec), "armed count differs from chain")
    `DLTQ_ASSERT_IMPLY(a_hold_empty, aclk, aresetn, state_reg == ST_IDLE,
        !hold_reg[ENT_W-1], "insert pass left a displaced entry")
    `DLTQ_ASSERT_IMPLY(a_head_armed, aclk, aresetn, state_reg == ST_IDLE && cur_v,
        armed_reg[cur_id], "head cell holds an idle slot")

endmodule
`default_nettype wire
